[rtl/core/bpwc_pkg.sv]
// Shared types, constants and helper functions for the partition weight block.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps

package bpwc_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD_ATOM = 2'd0,
		CMD_LOAD_PAIR = 2'd1,
		CMD_POINT     = 2'd2,
		CMD_UNUSED    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               op;
		logic [4:0]         first_atom;
		logic [4:0]         second_atom;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [17:0] radius_adjust;
	} item_t;

	typedef struct packed {
		logic [5:0] atom_count;
		logic       use_radii;
		logic       screening_enable;
	} cfg_t;

	localparam logic [1:0] CFG_ATOM_COUNT = 2'd0;
	localparam logic [1:0] CFG_USE_RADII  = 2'd1;
	localparam logic [1:0] CFG_SCREENING  = 2'd2;

	localparam logic [18:0]        CUTOFF_Q16 = 19'd327680;
	localparam logic [65:0]        CUTOFF_SQ  = 66'd107374182400;
	localparam logic signed [32:0] ONE_Q30    = 33'sd1073741824;
	localparam logic signed [32:0] HALF_Q30   = 33'sd536870912;
	localparam logic signed [32:0] THREE_Q30  = 33'sd3221225472;
	localparam logic signed [16:0] ADJ_LIMIT  = 17'sd32768;
	localparam logic [31:0]        WEIGHT_ONE = 32'h8000_0000;

	function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] d;
		logic signed [32:0] nd;
		d  = $signed({a[31], a}) - $signed({b[31], b});
		nd = -d;
		return d[32] ? nd[31:0] : d[31:0];
	endfunction

	function automatic logic signed [31:0] clamp_g(logic signed [39:0] x,
		logic signed [31:0] lim);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = 40'(lim);
		lo = -hi;
		if (x > hi)
			return hi[31:0];
		if (x < lo)
			return lo[31:0];
		return x[31:0];
	endfunction

endpackage

[rtl/core/bpwc_front.sv]
// Front end: takes requests, sorts them by command and drops those that do nothing.
// Depends on bpwc_pkg.
`timescale 1ns / 1ps

module bpwc_front #(
	parameter int MAX_ATOMS = 32
) (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [4:0]         first_atom,
	input  logic [4:0]         second_atom,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [17:0] radius_adjust,
	input  logic               q_full,
	output logic               q_push,
	output bpwc_pkg::item_t    q_item
);

	logic fa_ok;
	logic sa_ok;
	logic keep;

	assign fa_ok = {2'b00, first_atom} < 7'(MAX_ATOMS);
	assign sa_ok = {2'b00, second_atom} < 7'(MAX_ATOMS);

	always_comb begin
		case (bpwc_pkg::cmd_t'(cmd))
			bpwc_pkg::CMD_LOAD_ATOM: keep = fa_ok;
			bpwc_pkg::CMD_LOAD_PAIR: keep = fa_ok && sa_ok;
			bpwc_pkg::CMD_POINT:     keep = 1'b1;
			default:                 keep = 1'b0;
		endcase
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && keep;

	assign q_item.op            = bpwc_pkg::cmd_t'(cmd);
	assign q_item.first_atom    = first_atom;
	assign q_item.second_atom   = second_atom;
	assign q_item.pos_x         = pos_x;
	assign q_item.pos_y         = pos_y;
	assign q_item.pos_z         = pos_z;
	assign q_item.radius_adjust = radius_adjust;

endmodule

[rtl/core/bpwc_queue.sv]
// Two-entry request queue between front end and engine.
// Depends on bpwc_pkg.
`timescale 1ns / 1ps

module bpwc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bpwc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output bpwc_pkg::item_t head_item
);

	bpwc_pkg::item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/bpwc_engine.sv]
// Back end: stores atoms and pair adjustments, runs the per-point weight sequence
// on one shared multiplier, a bit-serial square root and divider. Depends on bpwc_pkg.
`timescale 1ns / 1ps

module bpwc_engine #(
	parameter int MAX_ATOMS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bpwc_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  bpwc_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [4:0]      atom_id,
	output logic [31:0]     weight,
	output logic            last
);

	localparam int AW  = $clog2(MAX_ATOMS);
	localparam int CW  = $clog2(MAX_ATOMS + 1);
	localparam int PD  = MAX_ATOMS * MAX_ATOMS;
	localparam int PAW = $clog2(PD);

	typedef enum logic [4:0] {
		ST_IDLE, ST_D_RD, ST_D_SUB, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_SUM, ST_SQ_INIT,
		ST_SQ_ITER, ST_SQ_DONE, ST_R_START, ST_R_LATCH, ST_P_RD, ST_P_CHK, ST_F_START,
		ST_F_DIV, ST_A1, ST_A2, ST_A3, ST_A4, ST_PL1, ST_PL2, ST_PL3, ST_W1, ST_W2,
		ST_W3, ST_P_NEXT, ST_O_RD, ST_O_WR
	} state_t;

	state_t state_q;

	logic [95:0]        coord_mem [MAX_ATOMS];
	logic signed [17:0] pair_mem  [PD];
	logic [31:0]        dist_mem  [MAX_ATOMS];
	logic [31:0]        wgt_mem   [MAX_ATOMS];

	logic [95:0]        coord_rd_q;
	logic signed [17:0] pair_rd_q;
	logic [31:0]        dist_rd_q;
	logic [31:0]        wgt_rd_q;

	logic [CW-1:0] i_q, j_q, n_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [31:0]  mx_q, my_q, mz_q;
	logic         pair_q;
	logic [65:0]  sum_q;
	logic [63:0]  sv_q, sr_q, sb_q;
	logic [31:0]  res_q;
	logic [32:0]  near_q;
	logic [31:0]  di_q, dj_q, wi_q, wj_q;
	logic [95:0]  ci_q;
	logic signed [16:0] a_q;
	logic [18:0]  rad_q;
	logic         neg_q;
	logic [18:0]  rem_q;
	logic [29:0]  quo_q;
	logic [4:0]   cnt_q;
	logic signed [31:0] g_q;
	logic signed [32:0] t_q;
	logic [1:0]   k_q;
	logic signed [65:0] prod_q;

	logic [AW-1:0]   i_idx, j_idx, ra;
	logic [2*AW-1:0] pr_lin, pw_lin;
	logic [CW-1:0]   i_nx, j_nx;
	logic [6:0]      ac_ext;
	logic [CW-1:0]   n_new;
	logic signed [32:0] mul_a, mul_b, g33;
	logic signed [65:0] p_sh16, p_sh30, p_sh31, p_sh32;
	logic signed [39:0] poly_v, adj_v;
	logic signed [31:0] poly_lim;
	logic [63:0] sq_try, sq_rn;
	logic        sq_ge;
	logic [19:0] rem2;
	logic        dv_ge;
	logic [18:0] rem_n;
	logic [29:0] quo_n;
	logic signed [31:0] quo_g;
	logic signed [32:0] fdiff;
	logic [31:0] fmag;
	logic [32:0] nmin;
	logic [31:0] w_new;
	logic        screened;
	logic        pop_atom, pop_pair;

	assign i_idx  = i_q[AW-1:0];
	assign j_idx  = j_q[AW-1:0];
	assign ra     = (state_q == ST_P_RD) ? j_idx : i_idx;
	assign i_nx   = i_q + CW'(1);
	assign j_nx   = j_q + CW'(1);
	assign pr_lin = (2*AW)'(i_idx) * (2*AW)'(MAX_ATOMS) + (2*AW)'(j_idx);
	assign pw_lin = (2*AW)'(AW'(q_item.first_atom)) * (2*AW)'(MAX_ATOMS)
		+ (2*AW)'(AW'(q_item.second_atom));
	assign ac_ext = {1'b0, cfg.atom_count};
	assign n_new  = (ac_ext > 7'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(ac_ext);

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign pop_atom = q_pop && q_item.op == bpwc_pkg::CMD_LOAD_ATOM;
	assign pop_pair = q_pop && q_item.op == bpwc_pkg::CMD_LOAD_PAIR;

	always_ff @(posedge clk) begin
		if (pop_atom)
			coord_mem[AW'(q_item.first_atom)] <= {q_item.pos_x, q_item.pos_y, q_item.pos_z};
		coord_rd_q <= coord_mem[ra];
	end

	always_ff @(posedge clk) begin
		if (pop_pair)
			pair_mem[PAW'(pw_lin)] <= q_item.radius_adjust;
		pair_rd_q <= pair_mem[PAW'(pr_lin)];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SQ_DONE && !pair_q)
			dist_mem[i_idx] <= res_q;
		dist_rd_q <= dist_mem[ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SQ_DONE && !pair_q)
			wgt_mem[i_idx] <= bpwc_pkg::WEIGHT_ONE;
		else if (state_q == ST_W3)
			wgt_mem[j_idx] <= w_new;
		else if (state_q == ST_P_NEXT && j_nx == i_q)
			wgt_mem[i_idx] <= wi_q;
		wgt_rd_q <= wgt_mem[ra];
	end

	// shared multiplier, one product per cycle
	assign g33 = 33'(g_q);
	always_comb begin
		case (state_q)
			ST_SQ_X: begin
				mul_a = $signed({1'b0, mx_q});
				mul_b = $signed({1'b0, mx_q});
			end
			ST_SQ_Y: begin
				mul_a = $signed({1'b0, my_q});
				mul_b = $signed({1'b0, my_q});
			end
			ST_SQ_Z: begin
				mul_a = $signed({1'b0, mz_q});
				mul_b = $signed({1'b0, mz_q});
			end
			ST_A1, ST_PL1: begin
				mul_a = g33;
				mul_b = g33;
			end
			ST_A3: begin
				mul_a = 33'(a_q);
				mul_b = t_q;
			end
			ST_PL2: begin
				mul_a = bpwc_pkg::THREE_Q30 - p_sh30[32:0];
				mul_b = g33;
			end
			ST_W1: begin
				mul_a = $signed({1'b0, wi_q});
				mul_b = bpwc_pkg::HALF_Q30 - g33;
			end
			ST_W2: begin
				mul_a = $signed({1'b0, wj_q});
				mul_b = bpwc_pkg::HALF_Q30 + g33;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign p_sh16   = prod_q >>> 16;
	assign p_sh30   = prod_q >>> 30;
	assign p_sh31   = prod_q >>> 31;
	assign p_sh32   = prod_q >>> 32;
	assign poly_v   = (k_q == 2'd2) ? p_sh32[39:0] : p_sh31[39:0];
	assign poly_lim = (k_q == 2'd2) ? 32'(bpwc_pkg::HALF_Q30) : 32'(bpwc_pkg::ONE_Q30);
	assign adj_v    = 40'(g_q) + p_sh16[39:0];
	assign w_new    = prod_q[61:30];

	assign sq_try = sr_q + sb_q;
	assign sq_ge  = sv_q >= sq_try;
	assign sq_rn  = sq_ge ? (sr_q >> 1) + sb_q : sr_q >> 1;

	assign rem2  = {rem_q, 1'b0};
	assign dv_ge = rem2 >= {1'b0, rad_q};
	assign rem_n = dv_ge ? 19'(rem2 - {1'b0, rad_q}) : rem2[18:0];
	assign quo_n = {quo_q[28:0], dv_ge};
	assign quo_g = neg_q ? -$signed({2'b00, quo_n}) : $signed({2'b00, quo_n});

	assign fdiff = $signed({1'b0, di_q}) - $signed({1'b0, dj_q});
	assign fmag  = fdiff[32] ? 32'(-fdiff) : fdiff[31:0];
	assign nmin  = ({1'b0, res_q} < near_q) ? {1'b0, res_q} : near_q;
	assign screened = cfg.screening_enable && ({1'b0, di_q} > near_q)
		&& ({1'b0, dist_rd_q} > near_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			px_q      <= '0;
			py_q      <= '0;
			pz_q      <= '0;
			mx_q      <= '0;
			my_q      <= '0;
			mz_q      <= '0;
			pair_q    <= 1'b0;
			sum_q     <= '0;
			sv_q      <= '0;
			sr_q      <= '0;
			sb_q      <= '0;
			res_q     <= '0;
			near_q    <= '0;
			di_q      <= '0;
			dj_q      <= '0;
			ci_q      <= '0;
			wi_q      <= '0;
			wj_q      <= '0;
			a_q       <= '0;
			rad_q     <= '0;
			neg_q     <= 1'b0;
			rem_q     <= '0;
			quo_q     <= '0;
			cnt_q     <= '0;
			g_q       <= '0;
			t_q       <= '0;
			k_q       <= '0;
			prod_q    <= '0;
			out_valid <= 1'b0;
			atom_id   <= '0;
			weight    <= '0;
			last      <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_item.op == bpwc_pkg::CMD_POINT && n_new != '0) begin
						px_q    <= q_item.pos_x;
						py_q    <= q_item.pos_y;
						pz_q    <= q_item.pos_z;
						n_q     <= n_new;
						i_q     <= '0;
						near_q  <= 33'h0_FFFF_FFFF;
						state_q <= ST_D_RD;
					end
				end
				ST_D_RD: state_q <= ST_D_SUB;
				ST_D_SUB: begin
					mx_q    <= bpwc_pkg::abs_diff(px_q, coord_rd_q[95:64]);
					my_q    <= bpwc_pkg::abs_diff(py_q, coord_rd_q[63:32]);
					mz_q    <= bpwc_pkg::abs_diff(pz_q, coord_rd_q[31:0]);
					pair_q  <= 1'b0;
					state_q <= ST_SQ_X;
				end
				ST_SQ_X: state_q <= ST_SQ_Y;
				ST_SQ_Y: begin
					sum_q   <= 66'(prod_q);
					state_q <= ST_SQ_Z;
				end
				ST_SQ_Z: begin
					sum_q   <= sum_q + 66'(prod_q);
					state_q <= ST_SQ_SUM;
				end
				ST_SQ_SUM: begin
					sum_q   <= sum_q + 66'(prod_q);
					state_q <= ST_SQ_INIT;
				end
				ST_SQ_INIT: begin
					if (sum_q[65:64] != 2'b00) begin
						res_q   <= 32'hFFFF_FFFF;
						state_q <= ST_SQ_DONE;
					end else if (pair_q && sum_q >= bpwc_pkg::CUTOFF_SQ) begin
						res_q   <= 32'(bpwc_pkg::CUTOFF_Q16);
						state_q <= ST_SQ_DONE;
					end else begin
						sv_q    <= sum_q[63:0];
						sr_q    <= '0;
						sb_q    <= pair_q ? 64'd1 << 36 : 64'd1 << 62;
						state_q <= ST_SQ_ITER;
					end
				end
				ST_SQ_ITER: begin
					if (sq_ge)
						sv_q <= sv_q - sq_try;
					sr_q <= sq_rn;
					sb_q <= sb_q >> 2;
					if (sb_q == 64'd1) begin
						res_q   <= sq_rn[31:0];
						state_q <= ST_SQ_DONE;
					end
				end
				ST_SQ_DONE: begin
					if (pair_q) begin
						rad_q   <= ({13'd0, res_q[18:0]} == res_q && res_q[18:0] < bpwc_pkg::CUTOFF_Q16)
							? res_q[18:0] : bpwc_pkg::CUTOFF_Q16;
						state_q <= ST_F_START;
					end else if (i_nx == n_q) begin
						near_q <= nmin + 33'(bpwc_pkg::CUTOFF_Q16);
						i_q    <= (n_q == CW'(1)) ? '0 : CW'(1);
						state_q <= (n_q == CW'(1)) ? ST_O_RD : ST_R_START;
					end else begin
						near_q  <= nmin;
						i_q     <= i_nx;
						state_q <= ST_D_RD;
					end
				end
				ST_R_START: state_q <= ST_R_LATCH;
				ST_R_LATCH: begin
					di_q    <= dist_rd_q;
					ci_q    <= coord_rd_q;
					wi_q    <= bpwc_pkg::WEIGHT_ONE;
					j_q     <= '0;
					state_q <= ST_P_RD;
				end
				ST_P_RD: state_q <= ST_P_CHK;
				ST_P_CHK: begin
					wj_q <= wgt_rd_q;
					dj_q <= dist_rd_q;
					if (pair_rd_q > 18'(bpwc_pkg::ADJ_LIMIT))
						a_q <= bpwc_pkg::ADJ_LIMIT;
					else if (pair_rd_q < -18'(bpwc_pkg::ADJ_LIMIT))
						a_q <= -bpwc_pkg::ADJ_LIMIT;
					else
						a_q <= pair_rd_q[16:0];
					mx_q   <= bpwc_pkg::abs_diff(ci_q[95:64], coord_rd_q[95:64]);
					my_q   <= bpwc_pkg::abs_diff(ci_q[63:32], coord_rd_q[63:32]);
					mz_q   <= bpwc_pkg::abs_diff(ci_q[31:0], coord_rd_q[31:0]);
					pair_q <= 1'b1;
					state_q <= screened ? ST_P_NEXT : ST_SQ_X;
				end
				ST_F_START: begin
					neg_q <= fdiff[32];
					if (fdiff == '0) begin
						g_q     <= '0;
						k_q     <= '0;
						state_q <= cfg.use_radii ? ST_A1 : ST_PL1;
					end else if (fmag >= 32'(rad_q)) begin
						g_q     <= fdiff[32] ? -32'(bpwc_pkg::ONE_Q30) : 32'(bpwc_pkg::ONE_Q30);
						k_q     <= '0;
						state_q <= cfg.use_radii ? ST_A1 : ST_PL1;
					end else begin
						rem_q   <= fmag[18:0];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_F_DIV;
					end
				end
				ST_F_DIV: begin
					rem_q <= rem_n;
					quo_q <= quo_n;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd29) begin
						g_q     <= quo_g;
						k_q     <= '0;
						state_q <= cfg.use_radii ? ST_A1 : ST_PL1;
					end
				end
				ST_A1: state_q <= ST_A2;
				ST_A2: begin
					t_q     <= bpwc_pkg::ONE_Q30 - p_sh30[32:0];
					state_q <= ST_A3;
				end
				ST_A3: state_q <= ST_A4;
				ST_A4: begin
					g_q     <= bpwc_pkg::clamp_g(adj_v, 32'(bpwc_pkg::ONE_Q30));
					state_q <= ST_PL1;
				end
				ST_PL1: state_q <= ST_PL2;
				ST_PL2: state_q <= ST_PL3;
				ST_PL3: begin
					g_q <= bpwc_pkg::clamp_g(poly_v, poly_lim);
					k_q <= k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? ST_W1 : ST_PL1;
				end
				ST_W1: state_q <= ST_W2;
				ST_W2: begin
					wi_q    <= w_new;
					state_q <= ST_W3;
				end
				ST_W3: state_q <= ST_P_NEXT;
				ST_P_NEXT: begin
					if (j_nx == i_q) begin
						if (i_nx == n_q) begin
							i_q     <= '0;
							state_q <= ST_O_RD;
						end else begin
							i_q     <= i_nx;
							state_q <= ST_R_START;
						end
					end else begin
						j_q     <= j_nx;
						state_q <= ST_P_RD;
					end
				end
				ST_O_RD: state_q <= ST_O_WR;
				ST_O_WR: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						atom_id   <= 5'(i_q);
						weight    <= wgt_rd_q;
						last      <= i_nx == n_q;
						if (i_nx == n_q) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_nx;
							state_q <= ST_O_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/becke_partition_weight_cutoff.sv]
// Top level of the Becke partition weight block: configuration registers, front end,
// request queue and engine. Depends on bpwc_pkg, bpwc_front, bpwc_queue, bpwc_engine.
//
// Usage: requests arrive on the in_valid/in_stall channel. cmd 0 stores an atom's
// coordinates, cmd 1 a pair radius adjustment, cmd 2 is a grid point; cmd 3 and loads
// at an atom index of MAX_ATOMS or above are dropped. A grid point gives one result
// per active atom on out_valid/out_stall, atom 0 first, last set on the final one.
// For a point the engine first finds the distance to each atom (no root is taken when
// the distance saturates), then works each row of atom pairs (a screened pair is
// skipped) and then sends the results. The work runs on the shared multiplier, the
// bit-serial square root (one root bit per cycle) and the bit-serial divider for the
// focal coordinate. A two-entry queue lets requests be taken while a point is being
// worked. If the receiver stalls, the result is held in the output register and the
// engine waits. Reset clears control state and sets atom_count 1, use_radii 0,
// screening_enable 1; stored atoms and adjustments are undefined until written.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
// only while idle, as the block itself does not enforce it.
`timescale 1ns / 1ps

module becke_partition_weight_cutoff #(
	parameter int MAX_ATOMS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [4:0]         first_atom,
	input  logic [4:0]         second_atom,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [17:0] radius_adjust,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         atom_id,
	output logic [31:0]        weight,
	output logic               last
);

	bpwc_pkg::cfg_t  cfg_q;
	bpwc_pkg::item_t push_item;
	bpwc_pkg::item_t head_item;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.atom_count       <= 6'd1;
			cfg_q.use_radii        <= 1'b0;
			cfg_q.screening_enable <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				bpwc_pkg::CFG_ATOM_COUNT: cfg_q.atom_count       <= cfg_data;
				bpwc_pkg::CFG_USE_RADII:  cfg_q.use_radii        <= cfg_data[0];
				bpwc_pkg::CFG_SCREENING:  cfg_q.screening_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bpwc_front #(
		.MAX_ATOMS(MAX_ATOMS)
	) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.first_atom    (first_atom),
		.second_atom   (second_atom),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.radius_adjust (radius_adjust),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	bpwc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	bpwc_engine #(
		.MAX_ATOMS(MAX_ATOMS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (head_valid),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.atom_id   (atom_id),
		.weight    (weight),
		.last      (last)
	);

endmodule
